// File: rtl/core/srtu_pkg.sv
package srtu_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_UPSERT = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_NOOP    = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] count;
    logic [15:0] depth;
  } entry_t;

  // running maxima handed down the chain
  typedef struct packed {
    logic [32:0] grp_end;
    logic [15:0] depth;
  } run_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_INS  = 2'd1,
    CMD_REPL = 2'd2,
    CMD_DEL  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      upper;   // insert after equal keys
    entry_t    item;
  } cell_cmd_t;

  typedef struct packed {
    logic lt;       // valid and base < key
    logic ahead;    // new entry goes after this cell
    logic hit;      // first valid cell with base == key
  } cell_flags_t;

endpackage

// File: rtl/core/srtu_ifs.sv
interface srtu_in_if (input logic clk);
  import srtu_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] group_base;
  logic [31:0] group_count;
  logic [15:0] traversal_depth;

  modport source (output valid, opcode, group_base, group_count, traversal_depth,
                  input ready);
  modport sink   (input valid, opcode, group_base, group_count, traversal_depth,
                  output ready);
endinterface

interface srtu_out_if (input logic clk);
  import srtu_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        key_found;
  logic [6:0]  entry_count;
  logic [15:0] max_depth;
  logic [32:0] max_group_end;

  modport source (output valid, status, key_found, entry_count, max_depth, max_group_end,
                  input ready);
  modport sink   (input valid, status, key_found, entry_count, max_depth, max_group_end,
                  output ready);
endinterface

// File: rtl/core/srtu_cell.sv
module srtu_cell
  import srtu_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  logic [OCC_W-1:0]  occ,
  input  cell_cmd_t         cmd,
  input  cell_flags_t       prev_flags,
  output cell_flags_t       flags,
  input  entry_t            left_entry,
  input  entry_t            right_entry,
  output entry_t            entry,
  input  run_t              left_run,
  output run_t              run
);

  entry_t      entry_r, entry_nxt;
  run_t        run_r, run_nxt;
  run_t        own;
  logic        valid, lt, eq;

  assign valid = OCC_W'(idx) < occ;
  assign lt    = valid && (entry_r.base < cmd.item.base);
  assign eq    = valid && (entry_r.base == cmd.item.base);

  assign flags.lt    = lt;
  assign flags.ahead = lt || (cmd.upper && eq);
  assign flags.hit   = eq && prev_flags.lt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.kind)
      CMD_INS: begin
        if (!flags.ahead) begin
          entry_nxt = prev_flags.ahead ? cmd.item : left_entry;
        end
      end
      CMD_REPL: begin
        if (flags.hit) begin
          entry_nxt.count = cmd.item.count;
          entry_nxt.depth = cmd.item.depth;
        end
      end
      CMD_DEL: begin
        if (!lt) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_comb begin
    own = '0;
    if (valid) begin
      own.grp_end = {1'b0, entry_r.base} + {1'b0, entry_r.count};
      own.depth   = entry_r.depth;
    end
    run_nxt.grp_end = (own.grp_end > left_run.grp_end) ? own.grp_end : left_run.grp_end;
    run_nxt.depth   = (own.depth > left_run.depth) ? own.depth : left_run.depth;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    run_r   <= run_nxt;
  end

  assign entry = entry_r;
  assign run   = run_r;

endmodule

// File: rtl/core/sorted_range_table_upsert_core.sv
// channel  | dir | words
// in_if    | in  | opcode, group_base, group_count, traversal_depth
// out_if   | out | status, key_found, entry_count, max_depth, max_group_end
//
// Each item is accepted in S_IDLE, updates the cell row in S_UPD, lets the maxima ripple
// down the row in S_SWEEP, and then loads the result register. The next word is taken
// only once the item before it has loaded its result, so items do not overlap.
// in_ready is high when no item is in flight, even while a result waits; a stalled
// result holds the next item at the end of its sweep.
// Reset empties the table at once; entry contents need no clearing.
module sorted_range_table_upsert_core
  import srtu_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  srtu_in_if.sink         in_if,
  srtu_out_if.source      out_if
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_UPD   = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [OCC_W-1:0]    cnt_r, cnt_nxt;
  opcode_t             op_r;
  entry_t              item_r;
  status_t             status_r, status_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic                out_found_r;
  logic [6:0]          out_count_r;
  run_t                out_run_r;

  cell_cmd_t           cmd;
  cmd_kind_t           kind;
  logic                upper;
  logic                found, full, in_acc, sweep_done, load_out;

  entry_t              ent   [TABLE_DEPTH];
  entry_t              lent  [TABLE_DEPTH];
  entry_t              rent  [TABLE_DEPTH];
  run_t                runs  [TABLE_DEPTH];
  run_t                lrun  [TABLE_DEPTH];
  cell_flags_t         flg   [TABLE_DEPTH];
  cell_flags_t         pflg  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hits;

  assign in_acc     = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign full       = (occ_r == OCC_W'(TABLE_DEPTH));
  assign found      = |hits;
  assign sweep_done = (state_r == S_SWEEP) && (cnt_r == OCC_W'(TABLE_DEPTH));
  assign load_out   = sweep_done && (!out_valid_r || out_if.ready);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        // virtual head: below every key, everything goes after it
        assign pflg[gi] = '{lt: 1'b1, ahead: 1'b1, hit: 1'b0};
        assign lent[gi] = '0;
        assign lrun[gi] = '0;
      end else begin : g_link
        assign pflg[gi] = flg[gi-1];
        assign lent[gi] = ent[gi-1];
        assign lrun[gi] = runs[gi-1];
      end
      if (gi == TABLE_DEPTH - 1) begin : g_tail
        assign rent[gi] = '0;
      end else begin : g_next
        assign rent[gi] = ent[gi+1];
      end
      assign hits[gi] = flg[gi].hit;

      srtu_cell u_cell (
        .clk         (clk),
        .idx         (IDX_W'(gi)),
        .occ         (occ_r),
        .cmd         (cmd),
        .prev_flags  (pflg[gi]),
        .flags       (flg[gi]),
        .left_entry  (lent[gi]),
        .right_entry (rent[gi]),
        .entry       (ent[gi]),
        .left_run    (lrun[gi]),
        .run         (runs[gi])
      );
    end
  endgenerate

  always_comb begin
    kind       = CMD_NONE;
    upper      = 1'b0;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    if (state_r == S_UPD) begin
      found_nxt = found;
      case (op_r)
        OP_CLEAR: begin
          occ_nxt    = '0;
          status_nxt = ST_APPLIED;
          found_nxt  = 1'b0;
        end
        OP_LOAD: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            kind       = CMD_INS;
            upper      = 1'b1;
            occ_nxt    = occ_r + 1'b1;
            status_nxt = ST_APPLIED;
          end
        end
        OP_UPSERT: begin
          if (item_r.count == '0) begin
            status_nxt = ST_NOOP;
          end else if (found) begin
            kind       = CMD_REPL;
            status_nxt = ST_APPLIED;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            kind       = CMD_INS;
            occ_nxt    = occ_r + 1'b1;
            status_nxt = ST_APPLIED;
          end
        end
        OP_REMOVE: begin
          if (found) begin
            kind       = CMD_DEL;
            occ_nxt    = occ_r - 1'b1;
            status_nxt = ST_APPLIED;
          end else begin
            status_nxt = ST_NOOP;
          end
        end
        default: status_nxt = ST_NOOP;
      endcase
    end
  end

  assign cmd = '{kind: kind, upper: upper, item: item_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_SWEEP;
        cnt_nxt   = '0;
      end
      S_SWEEP: begin
        if (!sweep_done) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r         <= opcode_t'(in_if.opcode);
      item_r.base  <= in_if.group_base;
      item_r.count <= in_if.group_count;
      item_r.depth <= in_if.traversal_depth;
    end
    status_r <= status_nxt;
    found_r  <= found_nxt;
    if (load_out) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= 7'(occ_r);
      out_run_r    <= runs[TABLE_DEPTH-1];
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.key_found     = out_found_r;
  assign out_if.entry_count   = out_count_r;
  assign out_if.max_depth     = out_run_r.depth;
  assign out_if.max_group_end = out_run_r.grp_end;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_accept_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_UPD)
    else $error("accepted word did not start an update");

  a_out_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SWEEP))
    else $error("result raised outside a sweep");

  a_occ_only_on_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_UPD |=> $stable(occ_r))
    else $error("occupancy changed outside an update");

endmodule

// File: dv/sorted_range_table_upsert_core_tb.sv
module sorted_range_table_upsert_core_tb;
  import srtu_pkg::*;

  localparam int STALL_LIMIT = 1200;

  typedef struct {
    status_t     status;
    logic        key_found;
    logic [6:0]  entry_count;
    logic [15:0] max_depth;
    logic [32:0] max_group_end;
  } table_summary_t;

  typedef enum {MIX_GROW, MIX_CHURN, MIX_DRAIN} traffic_mix_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  srtu_in_if  in_if (clk);
  srtu_out_if out_if (clk);

  sorted_range_table_upsert_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // shadow copy of the range table
  logic [31:0] tbl_base  [TABLE_DEPTH];
  logic [31:0] tbl_count [TABLE_DEPTH];
  logic [15:0] tbl_depth [TABLE_DEPTH];
  int unsigned tbl_occ;

  table_summary_t pending_summaries[$];
  int             mismatches;
  int             quiet_cycles;
  bit             in_idle_on;
  bit             out_idle_on;
  int             out_stall_left;

  function automatic void insert_range(int unsigned at, logic [31:0] b, logic [31:0] c,
                                       logic [15:0] d);
    for (int i = tbl_occ; i > at; i--) begin
      tbl_base[i]  = tbl_base[i-1];
      tbl_count[i] = tbl_count[i-1];
      tbl_depth[i] = tbl_depth[i-1];
    end
    tbl_base[at]  = b;
    tbl_count[at] = c;
    tbl_depth[at] = d;
    tbl_occ++;
  endfunction

  function automatic table_summary_t apply_to_table(opcode_t op, logic [31:0] b,
                                                    logic [31:0] c, logic [15:0] d);
    table_summary_t res;
    int unsigned    lo;
    int unsigned    hi;
    logic [32:0]    span_end;
    lo = 0;
    while (lo < tbl_occ && tbl_base[lo] < b) lo++;
    hi = lo;
    while (hi < tbl_occ && tbl_base[hi] == b) hi++;
    res.key_found = (lo < tbl_occ) && (tbl_base[lo] == b);
    res.status    = ST_NOOP;
    case (op)
      OP_CLEAR: begin
        tbl_occ       = 0;
        res.key_found = 1'b0;
        res.status    = ST_APPLIED;
      end
      OP_LOAD: begin
        if (tbl_occ >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          insert_range(hi, b, c, d);
          res.status = ST_APPLIED;
        end
      end
      OP_UPSERT: begin
        if (c == 0) begin
          res.status = ST_NOOP;
        end else if (res.key_found) begin
          tbl_count[lo] = c;
          tbl_depth[lo] = d;
          res.status    = ST_APPLIED;
        end else if (tbl_occ >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          insert_range(lo, b, c, d);
          res.status = ST_APPLIED;
        end
      end
      default: begin
        if (res.key_found) begin
          for (int i = lo; i + 1 < tbl_occ; i++) begin
            tbl_base[i]  = tbl_base[i+1];
            tbl_count[i] = tbl_count[i+1];
            tbl_depth[i] = tbl_depth[i+1];
          end
          tbl_occ--;
          res.status = ST_APPLIED;
        end
      end
    endcase
    res.max_depth     = '0;
    res.max_group_end = '0;
    for (int i = 0; i < tbl_occ; i++) begin
      span_end = {1'b0, tbl_base[i]} + {1'b0, tbl_count[i]};
      if (tbl_depth[i] > res.max_depth) res.max_depth = tbl_depth[i];
      if (span_end > res.max_group_end) res.max_group_end = span_end;
    end
    res.entry_count = 7'(tbl_occ);
    return res;
  endfunction

  // leaves valid high on return; a gap in the next call, or the caller, lowers it
  task automatic put_word(opcode_t op, logic [31:0] b, logic [31:0] c, logic [15:0] d);
    int gap;
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.opcode          <= op;
    in_if.group_base      <= b;
    in_if.group_count     <= c;
    in_if.traversal_depth <= d;
    do @(posedge clk); while (!in_if.ready);
    pending_summaries.push_back(apply_to_table(op, b, c, d));
  endtask

  function automatic logic [31:0] fresh_base();
    logic [31:0] b;
    bit          hit;
    do begin
      b   = $urandom;
      hit = 1'b0;
      for (int i = 0; i < tbl_occ; i++) if (tbl_base[i] == b) hit = 1'b1;
    end while (hit);
    return b;
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return tbl_occ != 0 ? tbl_base[$urandom_range(0, tbl_occ - 1)] : $urandom;
      5:             return $urandom_range(0, 15);
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default:       return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(1, 256);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 5))
      0:       return 16'hFFFF;
      1, 2:    return 16'($urandom_range(0, 32));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(traffic_mix_t mix);
    opcode_t op;
    int      r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:  op = r < 40 ? OP_LOAD : r < 88 ? OP_UPSERT : r < 99 ? OP_REMOVE : OP_CLEAR;
      MIX_CHURN: op = r < 20 ? OP_LOAD : r < 58 ? OP_UPSERT : r < 97 ? OP_REMOVE : OP_CLEAR;
      default:   op = r < 10 ? OP_LOAD : r < 30 ? OP_UPSERT : r < 99 ? OP_REMOVE : OP_CLEAR;
    endcase
    put_word(op, pick_base(), pick_count(), pick_depth());
  endtask

  task automatic test_empty_table();
    put_word(OP_REMOVE, 32'h0, 32'h1, 16'h1);
    put_word(OP_UPSERT, 32'h10, 32'h0, 16'h5);
    put_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_edges_and_duplicates();
    put_word(OP_LOAD,   32'h0000_0000, 32'h0000_0000, 16'h0000);
    put_word(OP_LOAD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_word(OP_UPSERT, 32'hFFFF_FFFF, 32'h0000_0001, 16'h1234);
    put_word(OP_UPSERT, 32'h0000_0000, 32'h0000_0000, 16'h0042);
    put_word(OP_LOAD,   32'h0000_0100, 32'h0000_0005, 16'h0007);
    put_word(OP_LOAD,   32'h0000_0100, 32'h0000_0009, 16'h0003);
    put_word(OP_LOAD,   32'h0000_0100, 32'h0000_0002, 16'h0001);
    put_word(OP_UPSERT, 32'h0000_0100, 32'h0000_0014, 16'h8000);
    put_word(OP_REMOVE, 32'h0000_0100, 32'h0, 16'h0);
    put_word(OP_REMOVE, 32'h0000_0055, 32'h0, 16'h0);
    put_word(OP_UPSERT, 32'h0000_0055, 32'hFFFF_FFFF, 16'hFFFF);
    put_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0);
    put_word(OP_REMOVE, 32'h0000_0000, 32'h0, 16'h0);
    put_word(OP_REMOVE, 32'h0000_0100, 32'h0, 16'h0);
    put_word(OP_REMOVE, 32'h0000_0100, 32'h0, 16'h0);
    put_word(OP_REMOVE, 32'h0000_0055, 32'h0, 16'h0);
    put_word(OP_LOAD,   32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    put_word(OP_LOAD,   32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    put_word(OP_CLEAR,  32'h0, 32'h0, 16'h0);
  endtask

  task automatic test_full_table();
    logic [31:0] b;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    while (tbl_occ < TABLE_DEPTH)
      put_word(OP_LOAD, $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 40)) : $urandom,
               pick_count(), pick_depth());
    b = tbl_base[$urandom_range(0, TABLE_DEPTH - 1)];
    put_word(OP_LOAD, b, pick_count(), pick_depth());
    put_word(OP_LOAD, fresh_base(), pick_count(), pick_depth());
    put_word(OP_UPSERT, b, 32'h0000_0007, 16'hFFFF);
    put_word(OP_UPSERT, fresh_base(), 32'h0000_0003, 16'h0001);
    put_word(OP_UPSERT, b, 32'h0, 16'h0002);
    put_word(OP_REMOVE, b, 32'h0, 16'h0);
    put_word(OP_REMOVE, fresh_base(), 32'h0, 16'h0);
    put_word(OP_UPSERT, fresh_base(), 32'hFFFF_FFFF, 16'h00FF);
    put_word(OP_CLEAR, 32'h0, 32'h0, 16'h0);
  endtask

  task automatic test_random_traffic();
    traffic_mix_t mix;
    for (int ph = 0; ph < 12; ph++) begin
      mix = traffic_mix_t'($urandom_range(0, 2));
      if (tbl_occ < 8) mix = MIX_GROW;
      else if (tbl_occ == TABLE_DEPTH && mix == MIX_GROW) mix = MIX_CHURN;
      case ($urandom_range(0, 3))
        0: begin in_idle_on = 1'b1; out_idle_on = 1'b1; end
        1: begin in_idle_on = 1'b1; out_idle_on = 1'b0; end
        2: begin in_idle_on = 1'b0; out_idle_on = 1'b1; end
        default: begin in_idle_on = 1'b0; out_idle_on = 1'b0; end
      endcase
      repeat (50) send_random(mix);
    end
  endtask

  task automatic test_quiet_tail();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (60) send_random(MIX_CHURN);
  endtask

  // result side back-pressure
  initial begin
    out_if.ready   <= 1'b0;
    out_stall_left  = 0;
    forever begin
      @(posedge clk);
      if (out_idle_on && out_stall_left > 0) begin
        out_stall_left--;
        out_if.ready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_left = $urandom_range(1, 14) - 1;
        out_if.ready   <= 1'b0;
      end else begin
        out_stall_left = 0;
        out_if.ready   <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    table_summary_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_summaries.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = pending_summaries.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.key_found !== want.key_found) begin
          $error("key_found: expected %0d, got %0d", want.key_found, out_if.key_found);
          mismatches++;
        end
        if (out_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_if.entry_count);
          mismatches++;
        end
        if (out_if.max_depth !== want.max_depth) begin
          $error("max_depth: expected %0h, got %0h", want.max_depth, out_if.max_depth);
          mismatches++;
        end
        if (out_if.max_group_end !== want.max_group_end) begin
          $error("max_group_end: expected %0h, got %0h", want.max_group_end,
                 out_if.max_group_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.opcode          <= OP_CLEAR;
    in_if.group_base      <= '0;
    in_if.group_count     <= '0;
    in_if.traversal_depth <= '0;
    quiet_cycles          <= 0;
    mismatches   = 0;
    tbl_occ      = 0;
    in_idle_on   = 1'b0;
    out_idle_on  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_edges_and_duplicates();
    test_full_table();
    test_random_traffic();
    test_quiet_tail();

    in_if.valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
